// File: rtl/cidr_pkg.sv
// Shared types, constants and mask helpers for the CIDR allow/deny filter.
// No dependencies; every rtl file imports this package.
`default_nettype none
package cidr_pkg;

  // Default rule table depth
  localparam int RULES_MAX_DEF = 16;

  // Operation codes
  localparam logic [1:0] OP_QUERY       = 2'd0;
  localparam logic [1:0] OP_WRITE_ALLOW = 2'd1;
  localparam logic [1:0] OP_WRITE_DENY  = 2'd2;

  // Address families
  localparam logic [1:0] FAM_IPV4          = 2'd0;
  localparam logic [1:0] FAM_IPV6          = 2'd1;
  localparam logic [1:0] FAM_UNIX_PATH     = 2'd2;
  localparam logic [1:0] FAM_UNIX_ABSTRACT = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] CFG_ALLOW_UNIX     = 8'd0;
  localparam logic [7:0] CFG_ALLOW_ABSTRACT = 8'd1;
  localparam logic [7:0] CFG_ALLOW_USED     = 8'd2;
  localparam logic [7:0] CFG_DENY_USED      = 8'd3;

  // Rule metadata: ipv4 rules carry this base plus their length
  localparam logic [7:0]  META_V4     = 8'hC0;
  localparam logic [7:0]  V4_LEN_MAX  = 8'd32;
  localparam logic [7:0]  V6_LEN_MAX  = 8'd128;
  localparam logic [7:0]  WORD_BITS   = 8'd64;
  localparam logic [31:0] V4_MAPPED   = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ALLOW,
    ST_DENY
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  rule_index;
    logic [1:0]  address_family;
    logic [7:0]  prefix_length;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } cidr_in_t;

  typedef struct packed {
    logic       allowed;
    logic [7:0] best_allow_length;
    logic       any_allow_match;
  } cidr_out_t;

  // One stored rule
  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
    logic [7:0]  meta;
  } rule_entry_t;

  // Verdict of the shared match unit for one rule
  typedef struct packed {
    logic       hit;
    logic [7:0] len;
  } match_res_t;

  // Top n bits set; n of 64 or more gives all ones
  function automatic logic [63:0] top_mask64(input logic [7:0] n);
    top_mask64 = ~(64'hFFFF_FFFF_FFFF_FFFF >> n);
  endfunction

  // Top n bits of a 32-bit word set; n of 32 or more gives all ones
  function automatic logic [31:0] top_mask32(input logic [7:0] n);
    top_mask32 = ~(32'hFFFF_FFFF >> n);
  endfunction

endpackage
`default_nettype wire

// File: rtl/cidr_rule_mem.sv
// Rule table memory: one write port, one registered read port.
// Depends on cidr_pkg for the entry type.
`default_nettype none
module cidr_rule_mem #(
  parameter int DEPTH = cidr_pkg::RULES_MAX_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire cidr_pkg::rule_entry_t wdata,
  input  wire logic [AW-1:0]         raddr,
  output cidr_pkg::rule_entry_t      rdata
);
  import cidr_pkg::*;

  rule_entry_t mem [DEPTH];
  rule_entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/cidr_match_unit.sv
// Shared rule compare unit: tests one stored rule against the query address.
// Depends on cidr_pkg for types, constants and mask helpers.
`default_nettype none
module cidr_match_unit (
  input  wire cidr_pkg::rule_entry_t rule,
  input  wire logic [1:0]            family,
  input  wire logic [63:0]           addr_high,
  input  wire logic [63:0]           addr_low,
  output cidr_pkg::match_res_t       res
);
  import cidr_pkg::*;

  logic        is_v4_rule;
  logic [7:0]  len_v4;
  logic [7:0]  len_v6;
  logic        v4_query;
  logic        v4_hit;
  logic [63:0] mask_hi;
  logic [63:0] mask_lo;
  logic        v6_hit;

  always_comb begin
    is_v4_rule = (rule.meta >= META_V4);

    // ipv4 rule: plain ipv4 query or ipv4-mapped ipv6 query
    len_v4 = rule.meta - META_V4;
    if (len_v4 > V4_LEN_MAX) len_v4 = V4_LEN_MAX;
    v4_query = (family == FAM_IPV4) ||
               ((family == FAM_IPV6) && (addr_high == 64'd0) &&
                (addr_low[63:32] == V4_MAPPED));
    v4_hit = v4_query &&
             (((addr_low[31:0] ^ rule.lower[31:0]) & top_mask32(len_v4)) == 32'd0);

    // ipv6 rule: upper word masked, lower word masked past 64 bits
    len_v6 = rule.meta;
    if (len_v6 > V6_LEN_MAX) len_v6 = V6_LEN_MAX;
    mask_hi = top_mask64(len_v6);
    mask_lo = (len_v6 > WORD_BITS) ? top_mask64(len_v6 - WORD_BITS) : 64'd0;
    v6_hit = (family == FAM_IPV6) &&
             (((addr_high ^ rule.upper) & mask_hi) == 64'd0) &&
             (((addr_low ^ rule.lower) & mask_lo) == 64'd0);

    res.hit = is_v4_rule ? v4_hit : v6_hit;
    res.len = is_v4_rule ? len_v4 : len_v6;
  end

endmodule
`default_nettype wire

// File: rtl/cidr_allow_deny_filter.sv
// CIDR allow/deny filter, top level; uses cidr_pkg, cidr_rule_mem, cidr_match_unit.
// Writes, unix queries and the unused code strobe straight after the decode state; an ip
// query scans the allow table, then the deny table only if an allow rule matched, each
// over its used count clipped to RULES_MAX, and strobes when the scans are done.
// One item at a time: busy holds off start until the strobe, the next is taken in the strobe cycle; no stall.
// Synchronous reset sets state and configuration; rule tables are not cleared.
`default_nettype none
module cidr_allow_deny_filter #(
  parameter int RULES_MAX = cidr_pkg::RULES_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input transactions
  input  wire logic               start,
  output logic                    busy,
  input  wire cidr_pkg::cidr_in_t in_item,
  // results
  output logic                    out_valid,
  output cidr_pkg::cidr_out_t     out_result,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import cidr_pkg::*;

  localparam int AW = (RULES_MAX > 1) ? $clog2(RULES_MAX) : 1;
  localparam int CW = $clog2(RULES_MAX + 1);

  state_t      state_r, state_nxt;
  cidr_in_t    item_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  best_r, best_nxt;
  logic        any_r, any_nxt;
  logic        deny_hit_r, deny_hit_nxt;
  logic        out_valid_r, out_valid_nxt;
  cidr_out_t   out_result_r, out_result_nxt;

  logic        allow_unix_r, allow_abstract_r;
  logic [4:0]  allow_used_r, deny_used_r;
  logic [CW-1:0] n_allow, n_deny;

  logic        wr_ok;
  logic        we_allow, we_deny;
  logic [AW-1:0] waddr;
  rule_entry_t wentry;
  logic [7:0]  plen_clip;
  rule_entry_t allow_rd, deny_rd, cur_rule;
  match_res_t  mres;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_unix_r     <= 1'b1;
      allow_abstract_r <= 1'b1;
      allow_used_r     <= 5'd0;
      deny_used_r      <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALLOW_UNIX:     allow_unix_r     <= cfg_data[0];
        CFG_ALLOW_ABSTRACT: allow_abstract_r <= cfg_data[0];
        CFG_ALLOW_USED:     allow_used_r     <= cfg_data[4:0];
        CFG_DENY_USED:      deny_used_r      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Used counts clipped to the table depth
  assign n_allow = (32'(allow_used_r) > RULES_MAX) ? CW'(RULES_MAX) : CW'(allow_used_r);
  assign n_deny  = (32'(deny_used_r) > RULES_MAX) ? CW'(RULES_MAX) : CW'(deny_used_r);

  // Rule write: clip length, clear bits past the prefix
  always_comb begin
    wentry = '0;
    plen_clip = item_r.prefix_length;
    if (item_r.address_family == FAM_IPV4) begin
      if (plen_clip > V4_LEN_MAX) plen_clip = V4_LEN_MAX;
      wentry.lower = {32'd0, item_r.address_low[31:0] & top_mask32(plen_clip)};
      wentry.meta  = META_V4 + plen_clip;
    end else begin
      if (plen_clip > V6_LEN_MAX) plen_clip = V6_LEN_MAX;
      wentry.upper = item_r.address_high & top_mask64(plen_clip);
      wentry.lower = (plen_clip > WORD_BITS) ?
                     (item_r.address_low & top_mask64(plen_clip - WORD_BITS)) : 64'd0;
      wentry.meta  = plen_clip;
    end
  end

  assign wr_ok = (item_r.address_family == FAM_IPV4 || item_r.address_family == FAM_IPV6) &&
                 (32'(item_r.rule_index) < RULES_MAX);
  assign we_allow = (state_r == ST_EXEC) && (item_r.operation == OP_WRITE_ALLOW) && wr_ok;
  assign we_deny  = (state_r == ST_EXEC) && (item_r.operation == OP_WRITE_DENY) && wr_ok;
  assign waddr    = AW'(item_r.rule_index);

  cidr_rule_mem #(.DEPTH(RULES_MAX)) u_allow_mem (
    .clk   (clk),
    .we    (we_allow),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (cnt_r[AW-1:0]),
    .rdata (allow_rd)
  );

  cidr_rule_mem #(.DEPTH(RULES_MAX)) u_deny_mem (
    .clk   (clk),
    .we    (we_deny),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (cnt_r[AW-1:0]),
    .rdata (deny_rd)
  );

  // Shared compare unit, fed by the table under scan
  assign cur_rule = (state_r == ST_DENY) ? deny_rd : allow_rd;

  cidr_match_unit u_match (
    .rule      (cur_rule),
    .family    (item_r.address_family),
    .addr_high (item_r.address_high),
    .addr_low  (item_r.address_low),
    .res       (mres)
  );

  // State register and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_item;
    end
    cnt_r        <= cnt_nxt;
    best_r       <= best_nxt;
    any_r        <= any_nxt;
    deny_hit_r   <= deny_hit_nxt;
    out_result_r <= out_result_nxt;
  end

  // Sequencer: decode, allow scan, deny scan, verdict
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = 1'b0;
    best_nxt       = best_r;
    any_nxt        = any_r;
    deny_hit_nxt   = deny_hit_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cnt_nxt        = '0;
        best_nxt       = 8'd0;
        any_nxt        = 1'b0;
        deny_hit_nxt   = 1'b0;
        out_result_nxt = '0;
        if (item_r.operation == OP_QUERY &&
            (item_r.address_family == FAM_IPV4 || item_r.address_family == FAM_IPV6)) begin
          state_nxt = ST_ALLOW;
        end else begin
          // writes, unix queries and the unused code answer at once
          if (item_r.operation == OP_QUERY) begin
            out_result_nxt.allowed = (item_r.address_family == FAM_UNIX_PATH) ?
                                     allow_unix_r : allow_abstract_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ALLOW: begin
        if (pend_r && mres.hit) begin
          any_nxt = 1'b1;
          if (mres.len > best_r) best_nxt = mres.len;
        end
        if (cnt_r < n_allow) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          cnt_nxt = '0;
          if (any_nxt) begin
            state_nxt = ST_DENY;
          end else begin
            out_result_nxt = '0;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      ST_DENY: begin
        if (pend_r && mres.hit && (mres.len >= best_r)) begin
          deny_hit_nxt = 1'b1;
        end
        if (cnt_r < n_deny) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          out_result_nxt.allowed           = any_r && !deny_hit_nxt;
          out_result_nxt.best_allow_length = best_r;
          out_result_nxt.any_allow_match   = any_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule
`default_nettype wire
